// ===== rtl/lrd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lrd_pkg;

  // Block codes that open a measurement block
  localparam logic [15:0] UPPER_CODE = 16'hEEFF;
  localparam logic [15:0] LOWER_CODE = 16'hDDFF;

  // Queue between the byte classifier and the data path
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // Widths of the position counters (cover the full range of the block parameters)
  localparam int BLK_W = 4;
  localparam int PT_W  = 6;
  localparam int CNT_W = 4;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_TIME,
    PH_LEN,
    PH_HEAD,
    PH_POINTS,
    PH_STATUS,
    PH_SUM
  } phase_e;

  typedef enum logic [3:0] {
    OP_TIME,
    OP_LEN_FAIL,
    OP_LEN_OK,
    OP_CODE_LO,
    OP_CODE_HI,
    OP_ENC_LO,
    OP_ENC_HI,
    OP_RANGE_LO,
    OP_RANGE_HI,
    OP_POINT,
    OP_STATUS_BYTE,
    OP_CHECK
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_LEN_BAD   = 2'd1,
    ST_CODE_BAD  = 2'd2,
    ST_CHECK_BAD = 2'd3
  } status_e;

  localparam logic KIND_POINT  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic [3:0] blk;
    logic [4:0] pt;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/lrd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lrd_front #(
  parameter int BLOCKS       = 12,
  parameter int POINTS       = 32,
  parameter int STATUS_BYTES = 6
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic [7:0]    marker_i,
  input  wire logic          q_full_i,
  output logic               in_stall_o,
  output logic               push_o,
  output lrd_pkg::entry_t    entry_o
);
  import lrd_pkg::*;

  localparam int PayloadBytes = BLOCKS * (4 + 3 * POINTS) + STATUS_BYTES;

  localparam logic [15:0]      PayloadLen = 16'(PayloadBytes);
  localparam logic [BLK_W-1:0] LastBlk    = BLK_W'(BLOCKS - 1);
  localparam logic [PT_W-1:0]  LastPt     = PT_W'(POINTS - 1);
  localparam logic [CNT_W-1:0] LastStat   = CNT_W'(STATUS_BYTES - 1);

  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [BLK_W-1:0] blk_q, blk_d;
  logic [PT_W-1:0]  pt_q, pt_d;
  logic [1:0]       part_q, part_d;
  logic [7:0]       len_lo_q, len_lo_d;
  logic             take;
  logic             push;
  op_e              op;

  assign in_stall_o = q_full_i;
  assign take       = in_valid_i && !q_full_i;

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    blk_d    = blk_q;
    pt_d     = pt_q;
    part_d   = part_q;
    len_lo_d = len_lo_q;
    push     = 1'b0;
    op       = OP_TIME;
    unique case (phase_q)
      PH_HUNT: begin
        if (data_byte_i == marker_i) begin
          phase_d = PH_TIME;
          cnt_d   = '0;
        end
      end
      PH_TIME: begin
        push  = 1'b1;
        op    = OP_TIME;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(7)) begin
          phase_d = PH_LEN;
          cnt_d   = '0;
        end
      end
      PH_LEN: begin
        if (cnt_q == '0) begin
          len_lo_d = data_byte_i;
          cnt_d    = CNT_W'(1);
        end else begin
          push  = 1'b1;
          cnt_d = '0;
          if ({data_byte_i, len_lo_q} == PayloadLen) begin
            op      = OP_LEN_OK;
            phase_d = PH_HEAD;
            blk_d   = '0;
          end else begin
            op      = OP_LEN_FAIL;
            phase_d = PH_HUNT;
          end
        end
      end
      PH_HEAD: begin
        push  = 1'b1;
        cnt_d = cnt_q + 1'b1;
        unique case (cnt_q[1:0])
          2'd0: op = OP_CODE_LO;
          2'd1: op = OP_CODE_HI;
          2'd2: op = OP_ENC_LO;
          default: begin
            op      = OP_ENC_HI;
            phase_d = PH_POINTS;
            cnt_d   = '0;
            pt_d    = '0;
            part_d  = '0;
          end
        endcase
      end
      PH_POINTS: begin
        push   = 1'b1;
        part_d = part_q + 1'b1;
        unique case (part_q)
          2'd0: op = OP_RANGE_LO;
          2'd1: op = OP_RANGE_HI;
          default: begin
            op     = OP_POINT;
            part_d = '0;
            if (pt_q == LastPt) begin
              pt_d = '0;
              if (blk_q == LastBlk) begin
                phase_d = (STATUS_BYTES > 0) ? PH_STATUS : PH_SUM;
                cnt_d   = '0;
              end else begin
                blk_d   = blk_q + 1'b1;
                phase_d = PH_HEAD;
              end
            end else begin
              pt_d = pt_q + 1'b1;
            end
          end
        endcase
      end
      PH_STATUS: begin
        push  = 1'b1;
        op    = OP_STATUS_BYTE;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastStat) begin
          phase_d = PH_SUM;
          cnt_d   = '0;
        end
      end
      PH_SUM: begin
        push    = 1'b1;
        op      = OP_CHECK;
        phase_d = PH_HUNT;
        cnt_d   = '0;
      end
      default: begin
        phase_d = PH_HUNT;
      end
    endcase
  end

  assign push_o  = take && push;
  assign entry_o = {op, data_byte_i, blk_q, pt_q[4:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      cnt_q    <= '0;
      blk_q    <= '0;
      pt_q     <= '0;
      part_q   <= '0;
      len_lo_q <= '0;
    end else if (take) begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      blk_q    <= blk_d;
      pt_q     <= pt_d;
      part_q   <= part_d;
      len_lo_q <= len_lo_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lrd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lrd_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire lrd_pkg::entry_t entry_i,
  input  wire logic            pop_i,
  output lrd_pkg::entry_t      entry_o,
  output logic                 full_o,
  output logic                 empty_o
);
  import lrd_pkg::*;

  entry_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lrd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lrd_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            empty_i,
  input  wire lrd_pkg::entry_t entry_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic                 result_kind_o,
  output logic [1:0]           status_code_o,
  output logic [63:0]          record_time_o,
  output logic                 upper_code_o,
  output logic [15:0]          encoder_value_o,
  output logic [3:0]           block_index_o,
  output logic [4:0]           point_index_o,
  output logic [15:0]          range_value_o,
  output logic [7:0]           intensity_value_o
);
  import lrd_pkg::*;

  logic [63:0] time_q, time_d;
  logic [7:0]  sum_q, sum_d;
  logic        bad_q, bad_d;
  logic [15:0] code_q, code_d;
  logic [15:0] enc_q, enc_d;
  logic [7:0]  rlo_q, rlo_d;
  logic [15:0] range_q, range_d;
  logic        out_valid_q;
  logic        kind_q;
  status_e     code_out_q, code_out_d;
  logic        upper_q;
  logic [15:0] enc_out_q;
  logic [3:0]  blk_out_q;
  logic [4:0]  pt_out_q;
  logic [15:0] range_out_q;
  logic [7:0]  inten_out_q;
  logic [63:0] time_out_q;
  logic        produce;
  logic        out_free;
  logic [7:0]  b;

  assign b        = entry_i.data;
  assign out_free = !out_valid_q || !out_stall_i;
  assign produce  = (entry_i.op == OP_POINT) || (entry_i.op == OP_LEN_FAIL) ||
                    (entry_i.op == OP_CHECK);
  assign pop_o    = !empty_i && (!produce || out_free);

  always_comb begin
    time_d     = time_q;
    sum_d      = sum_q;
    bad_d      = bad_q;
    code_d     = code_q;
    enc_d      = enc_q;
    rlo_d      = rlo_q;
    range_d    = range_q;
    code_out_d = ST_OK;
    unique case (entry_i.op)
      OP_TIME: time_d = {b, time_q[63:8]};
      OP_LEN_FAIL: code_out_d = ST_LEN_BAD;
      OP_LEN_OK: begin
        sum_d = '0;
        bad_d = 1'b0;
      end
      OP_CODE_LO: begin
        sum_d  = sum_q + b;
        code_d = {8'h00, b};
      end
      OP_CODE_HI: begin
        sum_d  = sum_q + b;
        code_d = {b, code_q[7:0]};
        if (code_d != UPPER_CODE && code_d != LOWER_CODE) begin
          bad_d = 1'b1;
        end
      end
      OP_ENC_LO: begin
        sum_d = sum_q + b;
        enc_d = {8'h00, b};
      end
      OP_ENC_HI: begin
        sum_d = sum_q + b;
        enc_d = {b, enc_q[7:0]};
      end
      OP_RANGE_LO: begin
        sum_d = sum_q + b;
        rlo_d = b;
      end
      OP_RANGE_HI: begin
        sum_d   = sum_q + b;
        range_d = {b, rlo_q};
      end
      OP_POINT:       sum_d = sum_q + b;
      OP_STATUS_BYTE: sum_d = sum_q + b;
      OP_CHECK: begin
        priority if (b != sum_q) begin
          code_out_d = ST_CHECK_BAD;
        end else if (bad_q) begin
          code_out_d = ST_CODE_BAD;
        end else begin
          code_out_d = ST_OK;
        end
      end
      default: code_out_d = ST_OK;
    endcase
  end

  // Data path state: only the record's own bytes shape it, no reset needed
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      time_q  <= time_d;
      sum_q   <= sum_d;
      bad_q   <= bad_d;
      code_q  <= code_d;
      enc_q   <= enc_d;
      rlo_q   <= rlo_d;
      range_q <= range_d;
    end
    if (pop_o && produce) begin
      time_out_q <= time_q;
      code_out_q <= code_out_d;
      if (entry_i.op == OP_POINT) begin
        kind_q      <= KIND_POINT;
        upper_q     <= (code_q == UPPER_CODE);
        enc_out_q   <= enc_q;
        blk_out_q   <= entry_i.blk;
        pt_out_q    <= entry_i.pt;
        range_out_q <= range_q;
        inten_out_q <= b;
      end else begin
        kind_q      <= KIND_STATUS;
        upper_q     <= 1'b0;
        enc_out_q   <= '0;
        blk_out_q   <= '0;
        pt_out_q    <= '0;
        range_out_q <= '0;
        inten_out_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o && produce) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_kind_o     = kind_q;
  assign status_code_o     = code_out_q;
  assign record_time_o     = time_out_q;
  assign upper_code_o      = upper_q;
  assign encoder_value_o   = enc_out_q;
  assign block_index_o     = blk_out_q;
  assign point_index_o     = pt_out_q;
  assign range_value_o     = range_out_q;
  assign intensity_value_o = inten_out_q;

endmodule

`default_nettype wire

// ===== rtl/lidar_record_deframer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sensor log record deframer. Bytes enter on data_byte_i, one per cycle at full
// rate: the front classifier accepts a byte every cycle unless its four-entry
// queue is full. It hunts for the start marker (written through cfg_we_i /
// cfg_data_i; the user must write it only while idle, which the block does not
// enforce), walks the 8-byte timestamp, the 2-byte length, the measurement
// blocks (code, encoder, points of range and intensity), the status bytes and
// the checksum byte, and queues one tagged item per byte that matters. The back
// data path drains one queued item per cycle unless the output stalls, assembles
// the little-endian words, sums the payload and loads the output register. A
// point result appears on the intensity byte of each point and a status result
// (length mismatch, bad block code, checksum mismatch or ok) at the end of each
// record; when nothing stalls, out_valid_o rises at the edge after the one that
// accepts its byte. The output register and the queue let the input keep flowing
// while a result waits on out_stall_i; sustained throughput is one byte per
// cycle, set by the single-byte-per-cycle queue and data path.
module lidar_record_deframer_top #(
  parameter int BLOCKS       = 12,
  parameter int POINTS       = 32,
  parameter int STATUS_BYTES = 6
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             result_kind_o,
  output logic [1:0]       status_code_o,
  output logic [63:0]      record_time_o,
  output logic             upper_code_o,
  output logic [15:0]      encoder_value_o,
  output logic [3:0]       block_index_o,
  output logic [4:0]       point_index_o,
  output logic [15:0]      range_value_o,
  output logic [7:0]       intensity_value_o
);
  import lrd_pkg::*;

  logic [7:0] marker_q;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  entry_t     q_in;
  entry_t     q_out;

  // Hold the start marker; the user must write it only while idle; not enforced
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= '0;
    end else if (cfg_we_i) begin
      marker_q <= cfg_data_i;
    end
  end

  // Classify each accepted byte and queue the ones the data path needs
  lrd_front #(
    .BLOCKS       (BLOCKS),
    .POINTS       (POINTS),
    .STATUS_BYTES (STATUS_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .data_byte_i (data_byte_i),
    .marker_i    (marker_q),
    .q_full_i    (q_full),
    .in_stall_o  (in_stall_o),
    .push_o      (q_push),
    .entry_o     (q_in)
  );

  // Decouple the classifier from the result side
  lrd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .pop_i   (q_pop),
    .entry_o (q_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Assemble words, check the sum and drive the result register
  lrd_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .empty_i           (q_empty),
    .entry_i           (q_out),
    .pop_o             (q_pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .result_kind_o     (result_kind_o),
    .status_code_o     (status_code_o),
    .record_time_o     (record_time_o),
    .upper_code_o      (upper_code_o),
    .encoder_value_o   (encoder_value_o),
    .block_index_o     (block_index_o),
    .point_index_o     (point_index_o),
    .range_value_o     (range_value_o),
    .intensity_value_o (intensity_value_o)
  );

  // Never drain an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_empty)
    else $error("queue popped while empty");

  // A full queue takes no new item
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_full |-> !q_push)
    else $error("queue pushed while full");

  // Point results carry an ok code and a block number in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o == KIND_POINT) |->
      (status_code_o == ST_OK && 32'(block_index_o) < BLOCKS))
    else $error("malformed point result");

  // Status results clear the per-point fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o == KIND_STATUS) |->
      (block_index_o == '0 && point_index_o == '0 && range_value_o == '0 &&
       intensity_value_o == '0 && encoder_value_o == '0 && !upper_code_o))
    else $error("status result carries point data");

endmodule

`default_nettype wire
